[hw/rtl/cmrg_pkg.sv]
package cmrg_pkg;

    localparam int unsigned MODULUS_WIDTH_DEF = 32;
    localparam int unsigned FIELD_WIDTH       = 32;
    localparam int unsigned RESULT_WIDTH      = 64;

    typedef enum logic [1:0] {
        ST_SOLVED = 2'd0,
        ST_NONE   = 2'd1,
        ST_ZERO   = 2'd2
    } t_status;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] residue_a;
        logic [FIELD_WIDTH-1:0] modulus_a;
        logic [FIELD_WIDTH-1:0] residue_b;
        logic [FIELD_WIDTH-1:0] modulus_b;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic [RESULT_WIDTH-1:0] merged_residue;
        logic [RESULT_WIDTH-1:0] merged_modulus;
    } t_out;

endpackage

[hw/rtl/cmrg_divider.sv]
module cmrg_divider #(
    parameter int unsigned W = cmrg_pkg::MODULUS_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_dividend,
    input  logic [W-1:0]   i_divisor,
    output logic           o_done,
    output logic [2*W-1:0] o_quotient,
    output logic [W-1:0]   o_remainder
);

    localparam int unsigned CW = $clog2(2*W+1);

    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [2*W-1:0] r_quo;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_div;
    logic [W:0]     w_shift;
    logic [W:0]     w_diff;
    logic           w_fits;

    always_comb begin
        w_shift = {r_rem, r_quo[2*W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_fits  = (w_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(2*W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[2*W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[W-1:0] : w_shift[W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hw/rtl/crt_congruence_merge.sv]
// Merges x = residue_a mod modulus_a and x = residue_b mod modulus_b into one congruence
// modulo lcm, or reports no solution or a zero modulus. Pulse start while busy is low; for
// nonzero moduli, busy rises the next cycle and stays high until the result appears on
// o_result for exactly one cycle with o_strobe, which the receiver must take then. A zero
// modulus answers in the cycle after start and leaves busy low. Otherwise all divisions run
// on one restoring divider, one quotient bit per cycle, one division per Euclid step.
module crt_congruence_merge #(
    parameter int unsigned MODULUS_WIDTH = cmrg_pkg::MODULUS_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  cmrg_pkg::t_in  i_item,
    output logic           o_strobe,
    output cmrg_pkg::t_out o_result
);

    localparam int unsigned W  = MODULUS_WIDTH;
    localparam int unsigned SW = W + 2;
    localparam int unsigned PW = 2*W + 2;
    localparam int unsigned RW = cmrg_pkg::RESULT_WIDTH;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_RED_A   = 16'h0002,
        S_RED_B   = 16'h0004,
        S_EUC_DIV = 16'h0008,
        S_EUC_MUL = 16'h0010,
        S_EUC_UPD = 16'h0020,
        S_GDIFF   = 16'h0040,
        S_DIV_D   = 16'h0080,
        S_DIV_MD  = 16'h0100,
        S_DIV_M1G = 16'h0200,
        S_LCM     = 16'h0400,
        S_QMOD    = 16'h0800,
        S_TMUL    = 16'h1000,
        S_TMOD    = 16'h2000,
        S_RMUL    = 16'h4000,
        S_RES     = 16'h8000
    } t_state;

    t_state          r_state;
    logic            r_launched;
    logic            r_strobe;
    cmrg_pkg::t_out  r_out;

    logic [W-1:0]    r_ra, r_rb, r_m1, r_m2, r_r1, r_r2;
    logic [W-1:0]    r_e0, r_e1, r_q, r_rem;
    logic [SW-1:0]   r_s0, r_s1;
    logic            r_neg, r_cneg;
    logic [W-1:0]    r_absd, r_qd, r_md, r_m1g, r_ctmp, r_inv, r_qm, r_t;
    logic [2*W-1:0]  r_lcm;
    logic [PW-1:0]   r_prod;

    logic            w_div_state;
    logic            w_div_start;
    logic [2*W-1:0]  w_dividend;
    logic [W-1:0]    w_divisor;
    logic            w_div_done;
    logic [2*W-1:0]  w_quo;
    logic [W-1:0]    w_drem;
    logic [W-1:0]    w_mul_a;
    logic [SW-1:0]   w_mul_b;
    logic [PW-1:0]   w_prod;
    logic [W:0]      w_cabs;
    logic [W-1:0]    w_m1_in, w_m2_in;

    assign w_m1_in = i_item.modulus_a[W-1:0];
    assign w_m2_in = i_item.modulus_b[W-1:0];

    always_comb begin
        w_dividend = '0;
        w_divisor  = r_md;
        unique case (r_state)
            S_RED_A:   begin w_dividend = (2*W)'(r_ra);   w_divisor = r_m1; end
            S_RED_B:   begin w_dividend = (2*W)'(r_rb);   w_divisor = r_m2; end
            S_EUC_DIV: begin w_dividend = (2*W)'(r_e0);   w_divisor = r_e1; end
            S_DIV_D:   begin w_dividend = (2*W)'(r_absd); w_divisor = r_e0; end
            S_DIV_MD:  begin w_dividend = (2*W)'(r_m2);   w_divisor = r_e0; end
            S_DIV_M1G: begin w_dividend = (2*W)'(r_m1);   w_divisor = r_e0; end
            S_QMOD:    begin w_dividend = (2*W)'(r_qd);   w_divisor = r_md; end
            S_TMOD:    begin w_dividend = r_prod[2*W-1:0]; w_divisor = r_md; end
            default:   begin w_dividend = '0;             w_divisor = r_md; end
        endcase
    end

    assign w_div_state = (r_state == S_RED_A) || (r_state == S_RED_B) ||
                         ((r_state == S_EUC_DIV) && (r_e1 != '0)) ||
                         (r_state == S_DIV_D) || (r_state == S_DIV_MD) ||
                         (r_state == S_DIV_M1G) || (r_state == S_QMOD) ||
                         (r_state == S_TMOD);
    assign w_div_start = w_div_state && !r_launched;

    cmrg_divider #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_drem)
    );

    always_comb begin
        w_mul_a = r_q;
        w_mul_b = r_s1;
        unique case (r_state)
            S_LCM:   begin w_mul_a = r_m1g; w_mul_b = SW'(r_m2); end
            S_TMUL:  begin w_mul_a = r_qm;  w_mul_b = SW'(r_inv); end
            S_RMUL:  begin w_mul_a = r_t;   w_mul_b = SW'(r_m1); end
            default: begin w_mul_a = r_q;   w_mul_b = r_s1; end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);
    assign w_cabs = r_s0[SW-1] ? (W+1)'(-r_s0) : (W+1)'(r_s0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (w_div_start) begin
                r_launched <= 1'b1;
            end
            if (w_div_done) begin
                r_launched <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (w_m1_in == '0 || w_m2_in == '0) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_RED_A;
                        end
                    end
                end
                S_RED_A:   if (w_div_done) r_state <= S_RED_B;
                S_RED_B:   if (w_div_done) r_state <= S_EUC_DIV;
                S_EUC_DIV: begin
                    if (r_e1 == '0) begin
                        r_state <= S_GDIFF;
                    end else if (w_div_done) begin
                        r_state <= S_EUC_MUL;
                    end
                end
                S_EUC_MUL: r_state <= S_EUC_UPD;
                S_EUC_UPD: r_state <= S_EUC_DIV;
                S_GDIFF:   r_state <= S_DIV_D;
                S_DIV_D: begin
                    if (w_div_done) begin
                        if (w_drem != '0) begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_DIV_MD;
                        end
                    end
                end
                S_DIV_MD:  if (w_div_done) r_state <= S_DIV_M1G;
                S_DIV_M1G: if (w_div_done) r_state <= S_LCM;
                S_LCM:     r_state <= S_QMOD;
                S_QMOD:    if (w_div_done) r_state <= S_TMUL;
                S_TMUL:    r_state <= S_TMOD;
                S_TMOD:    if (w_div_done) r_state <= S_RMUL;
                S_RMUL:    r_state <= S_RES;
                S_RES: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ra <= i_item.residue_a[W-1:0];
                r_rb <= i_item.residue_b[W-1:0];
                r_m1 <= w_m1_in;
                r_m2 <= w_m2_in;
                r_out.status         <= cmrg_pkg::ST_ZERO;
                r_out.merged_residue <= '0;
                r_out.merged_modulus <= '0;
            end
            S_RED_A: if (w_div_done) r_r1 <= w_drem;
            S_RED_B: begin
                if (w_div_done) begin
                    r_r2 <= w_drem;
                    r_e0 <= r_m1;
                    r_e1 <= r_m2;
                    r_s0 <= SW'(1);
                    r_s1 <= '0;
                end
            end
            S_EUC_DIV: begin
                if (w_div_done) begin
                    r_q   <= w_quo[W-1:0];
                    r_rem <= w_drem;
                end
            end
            S_EUC_MUL: r_prod <= w_prod;
            S_EUC_UPD: begin
                r_e0 <= r_e1;
                r_e1 <= r_rem;
                r_s0 <= r_s1;
                r_s1 <= r_s0 - r_prod[SW-1:0];
            end
            S_GDIFF: begin
                r_neg  <= (r_r2 < r_r1);
                r_absd <= (r_r2 < r_r1) ? (r_r1 - r_r2) : (r_r2 - r_r1);
            end
            S_DIV_D: begin
                if (w_div_done) begin
                    r_qd                 <= w_quo[W-1:0];
                    r_out.status         <= cmrg_pkg::ST_NONE;
                    r_out.merged_residue <= '0;
                    r_out.merged_modulus <= '0;
                end
            end
            S_DIV_MD:  if (w_div_done) r_md <= w_quo[W-1:0];
            S_DIV_M1G: if (w_div_done) r_m1g <= w_quo[W-1:0];
            S_LCM: begin
                r_prod <= w_prod;
                r_cneg <= r_s0[SW-1];
                r_ctmp <= (w_cabs >= (W+1)'(r_md)) ? W'(w_cabs - (W+1)'(r_md)) : W'(w_cabs);
            end
            S_QMOD: begin
                if (!r_launched) begin
                    r_lcm <= r_prod[2*W-1:0];
                    r_inv <= (r_cneg && r_ctmp != '0) ? (r_md - r_ctmp) : r_ctmp;
                end
                if (w_div_done) begin
                    r_qm <= (r_neg && w_drem != '0) ? (r_md - w_drem) : w_drem;
                end
            end
            S_TMUL:  r_prod <= w_prod;
            S_TMOD:  if (w_div_done) r_t <= w_drem;
            S_RMUL:  r_prod <= w_prod;
            S_RES: begin
                r_out.status         <= cmrg_pkg::ST_SOLVED;
                r_out.merged_residue <= RW'(r_prod[2*W-1:0]) + RW'(r_r1);
                r_out.merged_modulus <= RW'(r_lcm);
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && w_m1_in != '0 && w_m2_in != '0 |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_solved_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == cmrg_pkg::ST_SOLVED |->
            o_result.merged_residue < o_result.merged_modulus)
        else $error("merged residue not below lcm");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != cmrg_pkg::ST_SOLVED |->
            o_result.merged_residue == '0 && o_result.merged_modulus == '0)
        else $error("failed merge with nonzero fields");

    a_div_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> w_divisor != '0)
        else $error("divide by zero launched");

endmodule

[verif/tb_crt_congruence_merge.sv]
module tb_crt_congruence_merge;

    localparam int unsigned MW = cmrg_pkg::MODULUS_WIDTH_DEF;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    cmrg_pkg::t_in   i_item;
    logic            o_strobe;
    cmrg_pkg::t_out  o_result;

    cmrg_pkg::t_in   pending_items[$];
    cmrg_pkg::t_out  expected_merges[$];
    int     mismatch_count;
    int     gap_left;
    bit     stimulus_done;
    bit     drain_request;

    crt_congruence_merge DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic cmrg_pkg::t_out merge_congruences(cmrg_pkg::t_in it);
        cmrg_pkg::t_out r;
        logic [63:0] m1, m2, r1, r2, g, md, absd, q, inv, t, a, b, qq, tmp;
        longint      s0, s1, ts;
        bit          neg;
        r = '{status: cmrg_pkg::ST_ZERO, merged_residue: '0, merged_modulus: '0};
        m1 = 64'(it.modulus_a[MW-1:0]);
        m2 = 64'(it.modulus_b[MW-1:0]);
        if (m1 == 0 || m2 == 0) return r;
        r1 = 64'(it.residue_a[MW-1:0]) % m1;
        r2 = 64'(it.residue_b[MW-1:0]) % m2;
        a = m1; b = m2; s0 = 1; s1 = 0;
        while (b != 0) begin
            qq = a / b;
            tmp = a - qq * b; a = b; b = tmp;
            ts = s0 - longint'(qq) * s1; s0 = s1; s1 = ts;
        end
        g = a;
        neg = r2 < r1;
        absd = neg ? r1 - r2 : r2 - r1;
        if (absd % g != 0) begin
            r.status = cmrg_pkg::ST_NONE;
            return r;
        end
        md = m2 / g;
        q = (absd / g) % md;
        if (neg && q != 0) q = md - q;
        if (s0 < 0) inv = md - ((64'(0) - 64'(s0)) % md);
        else inv = 64'(s0);
        inv = inv % md;
        t = (q * inv) % md;
        r.status = cmrg_pkg::ST_SOLVED;
        r.merged_residue = t * m1 + r1;
        r.merged_modulus = (m1 / g) * m2;
        return r;
    endfunction

    function automatic logic [31:0] rand_modulus();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1, 2:    return $urandom_range(1, 64);
            3:       return $urandom_range(1, 4096) * $urandom_range(1, 64);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic cmrg_pkg::t_in make_item(logic [31:0] ra, logic [31:0] ma,
                                                logic [31:0] rb, logic [31:0] mb);
        cmrg_pkg::t_in it;
        it.residue_a = ra; it.modulus_a = ma;
        it.residue_b = rb; it.modulus_b = mb;
        return it;
    endfunction

    initial begin
        cmrg_pkg::t_in it;
        logic [31:0]   ma, mb, g;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        stimulus_done = 1'b0;
        drain_request = 1'b0;
        mismatch_count = 0;
        gap_left = 0;
        pending_items.push_back(make_item(5, 0, 3, 7));
        pending_items.push_back(make_item(5, 7, 3, 0));
        pending_items.push_back(make_item(0, 0, 0, 0));
        pending_items.push_back(make_item(2, 3, 3, 5));
        pending_items.push_back(make_item(1, 4, 2, 6));
        pending_items.push_back(make_item(1, 4, 3, 6));
        pending_items.push_back(make_item(9, 1, 4, 7));
        pending_items.push_back(make_item(9, 7, 4, 1));
        pending_items.push_back(make_item(0, 1, 0, 1));
        pending_items.push_back(make_item(20, 7, 100, 9));
        pending_items.push_back(make_item('1, '1, '1, '1));
        pending_items.push_back(make_item('1, '1, 32'hFFFF_FFFE, 32'hFFFF_FFFE));
        pending_items.push_back(make_item(3, '1, 7, 32'hFFFF_FFFD));
        pending_items.push_back(make_item(32'h8000_0000, 32'h8000_0000, 1, 32'h4000_0000));
        pending_items.push_back(make_item(12, 12, 12, 18));
        pending_items.push_back(make_item(7, 12, 1, 18));
        pending_items.push_back(make_item(6, 6, 6, 6));
        pending_items.push_back(make_item(32'h5555_5555, 32'hAAAA_AAAA,
                                          32'hAAAA_AAAA, 32'h5555_5555));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_items.size() == 0 && expected_merges.size() == 0);
        for (int n = 0; n < 450; n++) begin
            if (n == 200) begin
                wait (pending_items.size() == 0);
                drain_request = 1'b1;
                wait (expected_merges.size() == 0 && !start);
                drain_request = 1'b0;
            end
            ma = rand_modulus();
            mb = rand_modulus();
            if ($urandom_range(0, 2) == 0 && ma != 0) begin
                g = $urandom_range(1, 1000);
                ma = g * $urandom_range(1, 5000);
                mb = g * $urandom_range(1, 5000);
            end
            it = make_item($urandom(), ma, $urandom(), mb);
            if ($urandom_range(0, 2) == 0 && ma != 0 && mb != 0) begin
                it.residue_a = it.residue_a % ma;
                it.residue_b = ($urandom_range(0, 1) ? it.residue_a : it.residue_b) % mb;
            end
            pending_items.push_back(it);
            if (pending_items.size() > 8) wait (pending_items.size() <= 4);
        end
        stimulus_done = 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                start <= 1'b0;
                gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 600)
                                                       : $urandom_range(0, 3);
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0 && !drain_request) begin
                    i_item <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cmrg_pkg::t_out exp_r;
        if (i_rst_n) begin
            if (start && !busy) expected_merges.push_back(merge_congruences(i_item));
            if (o_strobe) begin
                if (expected_merges.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %p", o_result);
                end else begin
                    exp_r = expected_merges.pop_front();
                    if (o_result.status !== exp_r.status
                        || o_result.merged_residue !== exp_r.merged_residue
                        || o_result.merged_modulus !== exp_r.merged_modulus) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, o_result);
                    end
                end
            end
        end
    end

    initial begin
        wait (stimulus_done && pending_items.size() == 0 && !start);
        wait (expected_merges.size() == 0);
        repeat (4000) @(posedge i_clk);
        if (mismatch_count == 0 && expected_merges.size() == 0) begin
            $display("[crt_congruence_merge] OK");
        end else begin
            $display("[crt_congruence_merge] ERROR");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("[crt_congruence_merge] ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cmrg_pkg.sv
hw/rtl/cmrg_divider.sv
hw/rtl/crt_congruence_merge.sv
verif/tb_crt_congruence_merge.sv
